/* design/vector_length_rescale_unit_macros.svh */
// Assertion macros shared by the vector length rescale unit
`ifndef VECTOR_LENGTH_RESCALE_UNIT_MACROS_SVH
`define VECTOR_LENGTH_RESCALE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vlr check failed");

// Next-cycle implication, disabled during reset
`define VLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vlr check failed");

`endif

/* design/vlr_pkg.sv */
// Shared types and constants of the vector length rescale unit
package vlr_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF = 32;
	localparam int WIDE_W         = 49;
	localparam int CFG_W          = 16;
	localparam int LANE_EXTRA     = 5;
	localparam logic [CFG_W-1:0] RESCALE_MIN_RST = 16'd7;
	localparam logic [CFG_W-1:0] NORM_MIN_RST    = 16'd1;

	typedef enum logic [2:0] {
		CMD_RESCALE      = 3'd0,
		CMD_SAFE_RESCALE = 3'd1,
		CMD_NORMALIZE    = 3'd2,
		CMD_CROSS        = 3'd3,
		CMD_LENGTH       = 3'd4,
		CMD_DISTANCE     = 3'd5,
		CMD_DIRECTION    = 3'd6,
		CMD_DOT          = 3'd7
	} cmd_t;

	typedef enum logic [0:0] {
		REG_RESCALE_MIN = 1'b0,
		REG_NORM_MIN    = 1'b1
	} cfg_idx_t;

	// Per-item control handed to each divide lane
	typedef struct packed {
		logic zero;
		logic pass;
		logic scale;
	} lane_ctl_t;

endpackage

/* design/vlr_sqrt.sv */
// Pipelined integer square root, one result bit per stage
module vlr_sqrt import vlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic [2*COORD_BITS-1:0]   rad,
	output logic [COORD_BITS-1:0]     root
);

	localparam int CW = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;

	logic [CW+1:0] rem_s  [0:CW-1];
	logic [CW-1:0] root_s [0:CW-1];
	logic [PW-1:0] rad_s  [0:CW-1];

	genvar k;
	generate
		for (k = 0; k < CW; k++) begin : g_step
			logic [CW+1:0] rem_in;
			logic [CW-1:0] root_in;
			logic [PW-1:0] rad_in;
			logic [CW+1:0] r4;
			logic [CW+1:0] trial;
			logic          ge;

			// previous stage, or the radicand with a clear remainder
			always_comb begin
				if (k == 0) begin
					rem_in  = '0;
					root_in = '0;
					rad_in  = rad;
				end else begin
					rem_in  = rem_s[k-1];
					root_in = root_s[k-1];
					rad_in  = rad_s[k-1];
				end
				r4    = {rem_in[CW-1:0], rad_in[PW-1:PW-2]};
				trial = {root_in, 2'b01};
				ge    = (r4 >= trial);
			end

			always_ff @(posedge clk) begin
				rem_s[k]  <= ge ? (r4 - trial) : r4;
				root_s[k] <= {root_in[CW-2:0], ge};
				rad_s[k]  <= rad_in << 2;
			end
		end
	endgenerate

	assign root = root_s[CW-1];

endmodule

/* design/vlr_div_lane.sv */
// One component lane: magnitude times factor over length, saturate, optional scale
module vlr_div_lane import vlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  lane_ctl_t                    ctl,
	input  logic signed [COORD_BITS-1:0] v,
	input  logic [COORD_BITS-1:0]        mul_t,
	input  logic [COORD_BITS-1:0]        len,
	input  logic [COORD_BITS-1:0]        scl_t,
	output logic signed [COORD_BITS-1:0] r
);

	localparam int CW = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;
	localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	// multiply stage
	logic [CW-1:0] vm;
	logic [PW-1:0] prod_s1;
	logic          neg_s1;
	logic [CW-1:0] len_s1, v_s1, st_s1;
	lane_ctl_t     ctl_s1;

	assign vm = v[CW-1] ? (CW'(0) - v) : v;

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(vm) * PW'(mul_t);
		neg_s1  <= v[CW-1];
		len_s1  <= len;
		v_s1    <= v;
		st_s1   <= scl_t;
		ctl_s1  <= ctl;
	end

	// overflow check and divider set-up
	logic          ovf_s2, neg_s2;
	logic [CW-1:0] rem_s2, qn_s2, len_s2, v_s2, st_s2;
	lane_ctl_t     ctl_s2;

	always_ff @(posedge clk) begin
		ovf_s2 <= (prod_s1[PW-1:CW] >= len_s1);
		rem_s2 <= prod_s1[PW-1:CW];
		qn_s2  <= prod_s1[CW-1:0];
		neg_s2 <= neg_s1;
		len_s2 <= len_s1;
		v_s2   <= v_s1;
		st_s2  <= st_s1;
		ctl_s2 <= ctl_s1;
	end

	// restoring divider, one quotient bit per stage
	logic [CW-1:0] rem_d [0:CW-1];
	logic [CW-1:0] qn_d  [0:CW-1];
	logic [CW-1:0] len_d [0:CW-1];
	logic [CW-1:0] v_d   [0:CW-1];
	logic [CW-1:0] st_d  [0:CW-1];
	logic          ovf_d [0:CW-1];
	logic          neg_d [0:CW-1];
	lane_ctl_t     ctl_d [0:CW-1];

	genvar k;
	generate
		for (k = 0; k < CW; k++) begin : g_div
			logic [CW-1:0] rem_in, qn_in, len_in, v_in, st_in;
			logic          ovf_in, neg_in;
			lane_ctl_t     ctl_in;
			logic [CW:0]   r2;
			logic          ge;

			always_comb begin
				if (k == 0) begin
					rem_in = rem_s2;
					qn_in  = qn_s2;
					len_in = len_s2;
					v_in   = v_s2;
					st_in  = st_s2;
					ovf_in = ovf_s2;
					neg_in = neg_s2;
					ctl_in = ctl_s2;
				end else begin
					rem_in = rem_d[k-1];
					qn_in  = qn_d[k-1];
					len_in = len_d[k-1];
					v_in   = v_d[k-1];
					st_in  = st_d[k-1];
					ovf_in = ovf_d[k-1];
					neg_in = neg_d[k-1];
					ctl_in = ctl_d[k-1];
				end
				r2 = {rem_in, qn_in[CW-1]};
				ge = (r2 >= {1'b0, len_in});
			end

			always_ff @(posedge clk) begin
				rem_d[k] <= ge ? CW'(r2 - {1'b0, len_in}) : r2[CW-1:0];
				qn_d[k]  <= {qn_in[CW-2:0], ge};
				len_d[k] <= len_in;
				v_d[k]   <= v_in;
				st_d[k]  <= st_in;
				ovf_d[k] <= ovf_in;
				neg_d[k] <= neg_in;
				ctl_d[k] <= ctl_in;
			end
		end
	endgenerate

	// sign, saturation and the zero / pass-through cases
	logic [CW-1:0] q;
	logic          sat_q;
	logic [CW-1:0] r0;
	logic [CW-1:0] r0_s3, st_s3;
	logic          scale_s3;

	always_comb begin
		q = qn_d[CW-1];
		if (neg_d[CW-1])
			sat_q = ovf_d[CW-1] || (q[CW-1] && (|q[CW-2:0]));
		else
			sat_q = ovf_d[CW-1] || q[CW-1];
		if (ctl_d[CW-1].zero)
			r0 = '0;
		else if (ctl_d[CW-1].pass)
			r0 = v_d[CW-1];
		else if (sat_q)
			r0 = neg_d[CW-1] ? SMIN : SMAX;
		else
			r0 = neg_d[CW-1] ? (CW'(0) - q) : q;
	end

	always_ff @(posedge clk) begin
		r0_s3    <= r0;
		st_s3    <= st_d[CW-1];
		scale_s3 <= ctl_d[CW-1].scale;
	end

	// scale by the target length
	logic [CW-1:0] rm;
	logic [PW-1:0] sp_s4;
	logic [CW-1:0] r0_s4;
	logic          neg_s4, scale_s4;

	assign rm = r0_s3[CW-1] ? (CW'(0) - r0_s3) : r0_s3;

	always_ff @(posedge clk) begin
		sp_s4    <= PW'(rm) * PW'(st_s3);
		r0_s4    <= r0_s3;
		neg_s4   <= r0_s3[CW-1];
		scale_s4 <= scale_s3;
	end

	// drop the fraction toward zero and saturate
	logic [PW-1:0] sh;
	logic          sat_p;
	logic [CW-1:0] sc;
	logic [CW-1:0] r_s5;

	always_comb begin
		sh = sp_s4 >> FRAC_BITS;
		if (neg_s4)
			sat_p = (|sh[PW-1:CW]) || (sh[CW-1] && (|sh[CW-2:0]));
		else
			sat_p = |sh[PW-1:CW-1];
		if (sat_p)
			sc = neg_s4 ? SMIN : SMAX;
		else
			sc = neg_s4 ? (CW'(0) - sh[CW-1:0]) : sh[CW-1:0];
	end

	always_ff @(posedge clk) begin
		r_s5 <= scale_s4 ? sc : r0_s4;
	end

	assign r = r_s5;

endmodule

/* design/vector_length_rescale_unit.sv */
// Top level of the vector length rescale unit: front lanes, root, divide lanes, merge
// Fully pipelined: a new transaction may start every cycle, busy never rises, and each
// result appears on the done strobe after the front stages, the square root and the
// divide lanes. The receiver cannot stall, so results must be taken in the cycle they
// are strobed. The square root and the three divide lanes each resolve one result bit
// per pipeline stage. Threshold registers are written through the cfg port; the user
// must write them only while no transaction is in flight: the block does not enforce it.
`include "vector_length_rescale_unit_macros.svh"

module vector_length_rescale_unit import vlr_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cmd_t                         cmd,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic [COORD_BITS-1:0]        target_len,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] r_x,
	output logic signed [COORD_BITS-1:0] r_y,
	output logic signed [COORD_BITS-1:0] r_z,
	output logic [COORD_BITS-1:0]        scalar_len,
	output logic signed [WIDE_W-1:0]     scalar_wide,
	output logic                         degenerate,
	input  logic                         cfg_we,
	input  cfg_idx_t                     cfg_idx,
	input  logic [CFG_W-1:0]             cfg_wdata
);

	localparam int CW       = COORD_BITS;
	localparam int PW       = 2 * COORD_BITS;
	localparam int FB       = FRAC_BITS;
	localparam int XW       = ((PW + 2 > WIDE_W) ? PW + 2 : WIDE_W) + 1;
	localparam int LANE_LAT = COORD_BITS + LANE_EXTRA;
	localparam logic [CW-1:0]     SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0]     SMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [WIDE_W-1:0] WMAX = {1'b0, {(WIDE_W-1){1'b1}}};
	localparam logic [WIDE_W-1:0] WMIN = {1'b1, {(WIDE_W-1){1'b0}}};
	localparam logic [CW-1:0]     ONE  = {{(CW-1){1'b0}}, 1'b1} << FB;
	localparam logic [PW:0]       RND1 = {{(PW+1-FB){1'b0}}, {FB{1'b1}}};
	localparam logic [PW+1:0]     RND2 = {{(PW+2-FB){1'b0}}, {FB{1'b1}}};

	// threshold registers
	logic [CFG_W-1:0] rescale_min_q, normalize_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rescale_min_q   <= RESCALE_MIN_RST;
			normalize_min_q <= NORM_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RESCALE_MIN: rescale_min_q   <= cfg_wdata;
				REG_NORM_MIN:    normalize_min_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid line through the front stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// input register
	cmd_t          cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic [CW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	logic [CW-1:0] a_s1 [0:2];
	logic [CW-1:0] b_s1 [0:2];

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd;
		t_s1    <= target_len;
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
	end

	// front lanes: difference, cross products and dot terms
	logic signed [PW-1:0] m0_s2 [0:2];
	logic signed [PW-1:0] m1_s2 [0:2];
	logic [CW-1:0]        diff_s2 [0:2];
	logic [CW-1:0]        a_s2 [0:2];
	logic signed [PW:0]   cr_s3 [0:2];
	logic [CW-1:0]        diff_s3 [0:2];
	logic [CW-1:0]        a_s3 [0:2];
	logic [CW-1:0]        v_s4 [0:2];
	logic [CW-1:0]        v_s5 [0:2];
	logic [PW-1:0]        sq_s5 [0:2];
	logic [CW-1:0]        v_s6 [0:2];

	genvar l;
	generate
		for (l = 0; l < 3; l++) begin : g_front
			localparam int I1 = (l + 1) % 3;
			localparam int I2 = (l + 2) % 3;
			logic signed [CW-1:0] op0, op1, op2, op3;
			logic signed [CW:0]   sd;
			logic [CW-1:0]        dsat;
			logic signed [PW:0]   cadj;
			logic signed [PW:0]   ct;
			logic [CW-1:0]        csat;
			logic [CW-1:0]        vm;

			// operands: a.b term for dot, else the two cross terms
			always_comb begin
				if (cmd_s1 == CMD_DOT) begin
					op0 = a_s1[l];
					op1 = b_s1[l];
				end else begin
					op0 = a_s1[I1];
					op1 = b_s1[I2];
				end
				op2 = a_s1[I2];
				op3 = b_s1[I1];
				sd  = $signed({b_s1[l][CW-1], b_s1[l]}) - $signed({a_s1[l][CW-1], a_s1[l]});
				if (sd[CW] == sd[CW-1])
					dsat = sd[CW-1:0];
				else
					dsat = sd[CW] ? SMIN : SMAX;
			end

			always_ff @(posedge clk) begin
				m0_s2[l]   <= op0 * op1;
				m1_s2[l]   <= op2 * op3;
				diff_s2[l] <= dsat;
				a_s2[l]    <= a_s1[l];
			end

			always_ff @(posedge clk) begin
				cr_s3[l]   <= $signed({m0_s2[l][PW-1], m0_s2[l]})
					- $signed({m1_s2[l][PW-1], m1_s2[l]});
				diff_s3[l] <= diff_s2[l];
				a_s3[l]    <= a_s2[l];
			end

			// cross component: fraction dropped toward zero, then saturated
			always_comb begin
				cadj = cr_s3[l] + (cr_s3[l][PW] ? $signed(RND1) : $signed({(PW+1){1'b0}}));
				ct   = cadj >>> FB;
				if ((&ct[PW:CW-1]) || !(|ct[PW:CW-1]))
					csat = ct[CW-1:0];
				else
					csat = ct[PW] ? SMIN : SMAX;
			end

			// measured vector
			always_ff @(posedge clk) begin
				case (cmd_s3)
					CMD_CROSS:     v_s4[l] <= csat;
					CMD_DISTANCE:  v_s4[l] <= diff_s3[l];
					CMD_DIRECTION: v_s4[l] <= diff_s3[l];
					default:       v_s4[l] <= a_s3[l];
				endcase
			end

			assign vm = v_s4[l][CW-1] ? (CW'(0) - v_s4[l]) : v_s4[l];

			always_ff @(posedge clk) begin
				sq_s5[l] <= PW'(vm) * PW'(vm);
				v_s5[l]  <= v_s4[l];
				v_s6[l]  <= v_s5[l];
			end
		end
	endgenerate

	// dot product merge across the lanes
	logic signed [PW:0]   dsum_s3;
	logic signed [PW-1:0] dz_s3;
	logic signed [PW+1:0] dot_s4;
	logic signed [PW+1:0] dadj;
	logic signed [PW+1:0] dt;
	logic signed [XW-1:0] dx;
	logic [WIDE_W-1:0]    dsat;
	logic [WIDE_W-1:0]    dotw_s5, dotw_s6;
	logic [PW-1:0]        ss_s6;

	always_ff @(posedge clk) begin
		dsum_s3 <= $signed({m0_s2[0][PW-1], m0_s2[0]}) + $signed({m0_s2[1][PW-1], m0_s2[1]});
		dz_s3   <= m0_s2[2];
		dot_s4  <= (PW+2)'(dsum_s3) + (PW+2)'(dz_s3);
	end

	always_comb begin
		dadj = dot_s4 + (dot_s4[PW+1] ? $signed(RND2) : $signed({(PW+2){1'b0}}));
		dt   = dadj >>> FB;
		dx   = XW'(dt);
		if ((&dx[XW-1:WIDE_W-1]) || !(|dx[XW-1:WIDE_W-1]))
			dsat = dx[WIDE_W-1:0];
		else
			dsat = dx[XW-1] ? WMIN : WMAX;
	end

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		cmd_s3  <= cmd_s2;
		cmd_s4  <= cmd_s3;
		cmd_s5  <= cmd_s4;
		cmd_s6  <= cmd_s5;
		t_s2    <= t_s1;
		t_s3    <= t_s2;
		t_s4    <= t_s3;
		t_s5    <= t_s4;
		t_s6    <= t_s5;
		dotw_s5 <= dsat;
		dotw_s6 <= dotw_s5;
		ss_s6   <= sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	// squared length in Q32.16, saturated, or the dot product for the dot command
	logic [XW-1:0]     ssx;
	logic [WIDE_W-1:0] swide_c;

	always_comb begin
		ssx = XW'(ss_s6 >> FB);
		if (cmd_s6 == CMD_DOT)
			swide_c = dotw_s6;
		else if (|ssx[XW-1:WIDE_W-1])
			swide_c = WMAX;
		else
			swide_c = ssx[WIDE_W-1:0];
	end

	// square root and its side data
	logic [CW-1:0] len;

	vlr_sqrt #(
		.COORD_BITS (COORD_BITS)
	) u_sqrt (
		.clk  (clk),
		.rad  (ss_s6),
		.root (len)
	);

	logic              rt_vld_s [0:CW-1];
	cmd_t              rt_cmd_s [0:CW-1];
	logic [CW-1:0]     rt_t_s   [0:CW-1];
	logic [WIDE_W-1:0] rt_sw_s  [0:CW-1];
	logic [CW-1:0]     rt_v_s   [0:CW-1][0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CW; i++)
				rt_vld_s[i] <= 1'b0;
		end else begin
			rt_vld_s[0] <= vld_s6;
			for (int i = 1; i < CW; i++)
				rt_vld_s[i] <= rt_vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		rt_cmd_s[0] <= cmd_s6;
		rt_t_s[0]   <= t_s6;
		rt_sw_s[0]  <= swide_c;
		for (int j = 0; j < 3; j++)
			rt_v_s[0][j] <= v_s6[j];
		for (int i = 1; i < CW; i++) begin
			rt_cmd_s[i] <= rt_cmd_s[i-1];
			rt_t_s[i]   <= rt_t_s[i-1];
			rt_sw_s[i]  <= rt_sw_s[i-1];
			for (int j = 0; j < 3; j++)
				rt_v_s[i][j] <= rt_v_s[i-1][j];
		end
	end

	// per-command lane control from the length
	cmd_t          lc;
	logic          len_zero, over_r, over_n;
	lane_ctl_t     lctl;
	logic [CW-1:0] lmul;
	logic          ldeg;
	logic [CW-1:0] lslen;

	always_comb begin
		lc       = rt_cmd_s[CW-1];
		len_zero = (len == '0);
		over_r   = (len > CW'(rescale_min_q));
		over_n   = (len > CW'(normalize_min_q));
		lctl     = '{zero: 1'b1, pass: 1'b0, scale: 1'b0};
		lmul     = ONE;
		ldeg     = 1'b0;
		lslen    = len;
		case (lc)
			CMD_RESCALE: begin
				lctl.zero = len_zero;
				lmul      = rt_t_s[CW-1];
				ldeg      = len_zero;
			end
			CMD_SAFE_RESCALE: begin
				lctl.zero = 1'b0;
				lctl.pass = !over_r;
				lmul      = rt_t_s[CW-1];
				ldeg      = !over_r;
			end
			CMD_NORMALIZE: begin
				lctl.zero = !over_n;
				ldeg      = !over_n;
			end
			CMD_CROSS: begin
				lctl.zero = len_zero;
				ldeg      = len_zero;
			end
			CMD_DIRECTION: begin
				lctl.zero  = !over_n;
				lctl.scale = 1'b1;
				ldeg       = !over_n;
			end
			CMD_LENGTH, CMD_DISTANCE: begin
				ldeg = len_zero;
			end
			CMD_DOT: begin
				lslen = '0;
			end
			default: ;
		endcase
	end

	// three divide lanes
	logic [CW-1:0] lane_r [0:2];

	generate
		for (l = 0; l < 3; l++) begin : g_lane
			vlr_div_lane #(
				.COORD_BITS (COORD_BITS),
				.FRAC_BITS  (FRAC_BITS)
			) u_lane (
				.clk   (clk),
				.ctl   (lctl),
				.v     (rt_v_s[CW-1][l]),
				.mul_t (lmul),
				.len   (len),
				.scl_t (rt_t_s[CW-1]),
				.r     (lane_r[l])
			);
		end
	endgenerate

	// scalar results ride alongside the lanes
	logic              ln_vld_s  [0:LANE_LAT-1];
	logic [CW-1:0]     ln_slen_s [0:LANE_LAT-1];
	logic [WIDE_W-1:0] ln_sw_s   [0:LANE_LAT-1];
	logic              ln_deg_s  [0:LANE_LAT-1];
	logic              ln_pass_s [0:LANE_LAT-1];
	logic              ln_dot_s  [0:LANE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++)
				ln_vld_s[i] <= 1'b0;
		end else begin
			ln_vld_s[0] <= rt_vld_s[CW-1];
			for (int i = 1; i < LANE_LAT; i++)
				ln_vld_s[i] <= ln_vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		ln_slen_s[0] <= lslen;
		ln_sw_s[0]   <= rt_sw_s[CW-1];
		ln_deg_s[0]  <= ldeg;
		ln_pass_s[0] <= lctl.pass;
		ln_dot_s[0]  <= (lc == CMD_DOT);
		for (int i = 1; i < LANE_LAT; i++) begin
			ln_slen_s[i] <= ln_slen_s[i-1];
			ln_sw_s[i]   <= ln_sw_s[i-1];
			ln_deg_s[i]  <= ln_deg_s[i-1];
			ln_pass_s[i] <= ln_pass_s[i-1];
			ln_dot_s[i]  <= ln_dot_s[i-1];
		end
	end

	// result ports
	assign done        = ln_vld_s[LANE_LAT-1];
	assign r_x         = lane_r[0];
	assign r_y         = lane_r[1];
	assign r_z         = lane_r[2];
	assign scalar_len  = ln_slen_s[LANE_LAT-1];
	assign scalar_wide = ln_sw_s[LANE_LAT-1];
	assign degenerate  = ln_deg_s[LANE_LAT-1];

	// checks
	`VLR_ASSERT_NOW(a_deg_zero_vec, clk, arst_n,
		done && degenerate && !ln_pass_s[LANE_LAT-1],
		r_x == '0 && r_y == '0 && r_z == '0)
	`VLR_ASSERT_NOW(a_dot_scalars, clk, arst_n, done && ln_dot_s[LANE_LAT-1],
		!degenerate && scalar_len == '0 && r_x == '0 && r_y == '0 && r_z == '0)
	`VLR_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_we && cfg_idx == REG_NORM_MIN,
		normalize_min_q == $past(cfg_wdata))

endmodule
